// ===== rtl/cfac_pkg.sv =====
// Shared types, constants and the CRC-16/CCITT byte update for the CRC frame block.
// Used by every module under rtl; depends on nothing else.
package cfac_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CRC_W      = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW   = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET = 2'd1;

   localparam logic [CRC_W-1:0] CRC_PRESET_RESET = 16'hFFFF;

   typedef enum logic {
      MODE_GENERATE = 1'b0,
      MODE_CHECK    = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      JOB_GEN_BYTE,
      JOB_GEN_LAST,
      JOB_CHK_BYTE,
      JOB_CHK_LAST_BYTE,
      JOB_CHK_LAST
   } job_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_is_data;
      logic              out_last;
      logic [1:0]        frame_status;
      logic [CRC_W-1:0]  computed_crc;
      logic              error_flag;
   } rsp_type;

   typedef struct packed {
      job_kind_type      kind;
      logic [BYTE_W-1:0] data_byte;
      logic [CRC_W-1:0]  crc;
      status_type        status;
      logic              err_old;
      logic              err_new;
   } job_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] x;
      logic [CRC_W-1:0]  xw;
      x  = crc[CRC_W-1:BYTE_W] ^ b;
      x  = x ^ (x >> 4);
      xw = {{(CRC_W-BYTE_W){1'b0}}, x};
      return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
   endfunction

endpackage

// ===== rtl/cfac_front.sv =====
// Front end: holds the configuration registers, accepts input words, runs the CRC,
// the two-word delay line and the frame status, and emits at most one job per input word.
// Depends on cfac_pkg.
module cfac_front
   import cfac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata,
   input  logic                 accept,
   input  req_type              req_data,
   output logic                 job_push,
   output job_type              job_data
);

   mode_type          mode_ff;
   logic [CRC_W-1:0]  preset_ff;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] delay0_ff, delay0_in, delay1_ff, delay1_in;
   logic [1:0]        seen_ff, seen_in;
   logic              err_ff, err_in;

   logic [CRC_W-1:0]  crc_base, crc_gen, crc_chk;
   logic [CRC_W-1:0]  rx_crc;
   status_type        status;

   always_comb begin
      crc_base = (seen_ff == 2'd0) ? preset_ff : crc_ff;
      crc_gen  = crc_byte(crc_base, req_data.in_byte);
      crc_chk  = crc_byte(crc_base, delay0_ff);
      rx_crc   = {req_data.in_byte, delay1_ff};

      crc_in    = crc_ff;
      delay0_in = delay0_ff;
      delay1_in = delay1_ff;
      seen_in   = seen_ff;
      err_in    = err_ff;
      status    = STATUS_OK;
      job_push  = 1'b0;

      job_data.kind      = JOB_GEN_BYTE;
      job_data.data_byte = req_data.in_byte;
      job_data.crc       = crc_gen;
      job_data.status    = STATUS_OK;
      job_data.err_old   = err_ff;
      job_data.err_new   = err_ff;

      if (accept) begin
         crc_in = crc_base;
         if (mode_ff == MODE_GENERATE) begin
            crc_in   = crc_gen;
            job_push = 1'b1;
            if (req_data.in_last) begin
               job_data.kind = JOB_GEN_LAST;
               seen_in       = 2'd0;
            end else if (seen_ff != 2'd2) begin
               seen_in = seen_ff + 2'd1;
            end
         end else begin
            delay0_in          = delay1_ff;
            delay1_in          = req_data.in_byte;
            job_data.data_byte = delay0_ff;
            job_data.crc       = crc_base;
            if (seen_ff == 2'd2) begin
               crc_in       = crc_chk;
               job_data.crc = crc_chk;
            end
            if (!req_data.in_last) begin
               if (seen_ff == 2'd2) begin
                  job_push      = 1'b1;
                  job_data.kind = JOB_CHK_BYTE;
               end else begin
                  seen_in = seen_ff + 2'd1;
               end
            end else begin
               job_push = 1'b1;
               if (seen_ff == 2'd0) begin
                  status = STATUS_SHORT;
               end else if (rx_crc == crc_in) begin
                  status = STATUS_OK;
               end else begin
                  status = STATUS_MISMATCH;
               end
               job_data.kind    = (seen_ff == 2'd2) ? JOB_CHK_LAST_BYTE : JOB_CHK_LAST;
               job_data.status  = status;
               err_in           = (status != STATUS_OK);
               job_data.err_new = err_in;
               seen_in          = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_GENERATE;
         preset_ff <= CRC_PRESET_RESET;
         crc_ff    <= CRC_PRESET_RESET;
         delay0_ff <= '0;
         delay1_ff <= '0;
         seen_ff   <= 2'd0;
         err_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_MODE) begin
            mode_ff <= mode_type'(csr_wdata[0]);
         end
         if (csr_valid && csr_index == CSR_PRESET) begin
            preset_ff <= csr_wdata;
         end
         crc_ff    <= crc_in;
         delay0_ff <= delay0_in;
         delay1_ff <= delay1_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
      end
   end

endmodule

// ===== rtl/cfac_queue.sv =====
// Job queue between the front end and the back end, built from flip-flops.
// Depends on cfac_pkg.
module cfac_queue
   import cfac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_data
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/cfac_back.sv =====
// Back end: expands each queued job into one to three result words and holds
// them in the output register. Depends on cfac_pkg.
module cfac_back
   import cfac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;
   rsp_type    item;
   logic       final_item;
   logic       load;

   always_comb begin
      item.out_byte     = head_data.data_byte;
      item.out_is_data  = 1'b1;
      item.out_last     = 1'b0;
      item.frame_status = STATUS_OK;
      item.computed_crc = head_data.crc;
      item.error_flag   = head_data.err_old;
      final_item        = 1'b1;

      unique case (head_data.kind)
         JOB_GEN_BYTE, JOB_CHK_BYTE: begin
            final_item = 1'b1;
         end
         JOB_GEN_LAST: begin
            final_item = (idx_ff == 2'd2);
            if (idx_ff == 2'd1) begin
               item.out_byte = head_data.crc[BYTE_W-1:0];
            end else if (idx_ff == 2'd2) begin
               item.out_byte = head_data.crc[CRC_W-1:BYTE_W];
               item.out_last = 1'b1;
            end
         end
         JOB_CHK_LAST_BYTE, JOB_CHK_LAST: begin
            if (head_data.kind == JOB_CHK_LAST_BYTE && idx_ff == 2'd0) begin
               final_item = 1'b0;
            end else begin
               item.out_byte     = '0;
               item.out_is_data  = 1'b0;
               item.out_last     = 1'b1;
               item.frame_status = head_data.status;
               item.error_flag   = head_data.err_new;
            end
         end
         default: begin
            final_item = 1'b1;
         end
      endcase

      load     = head_valid && (!valid_ff || !rsp_stall);
      pop      = load && final_item;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      rsp_in   = rsp_ff;
      if (load) begin
         idx_in   = final_item ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
         rsp_in   = item;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/crc16_frame_append_check.sv =====
// Top level of the CRC-16/CCITT frame generator and checker.
// Instantiates cfac_front, cfac_queue and cfac_back; depends on cfac_pkg.
//
// The block takes one input word per cycle while req_stall is low and gives one
// result word per cycle while rsp_stall is low. Most input words cause one result
// word (or none for the first two words of a check-mode frame), so the sustained
// rate is one word per cycle; a generate-mode last word causes three result words
// and a check-mode last word up to two, and these leave one after another because
// the output register sends one word per cycle. A four-entry job queue between the
// front end and the output side absorbs these bursts and stalls on either side; a
// result passes through the job queue and then the output register. Configuration
// writes are always ready and must only be made while the block is idle.
module crc16_frame_append_check
   import cfac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CRC_W-1:0]     csr_wdata
);

   logic    accept;
   logic    job_push;
   job_type job_data;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_data;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   cfac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .job_push  (job_push),
      .job_data  (job_data)
   );

   cfac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   cfac_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
